[src/sbms_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sbms_pkg: shared types for the sorted block merge/split unit
// Block size, index widths, front-to-back write port, merge command and back-end states.
// ----------------------------------------------------------------------------
package sbms_pkg;

	localparam int BLOCK_MAX = 64;
	localparam int ADDR_W    = (BLOCK_MAX > 1) ? $clog2(BLOCK_MAX) : 1;
	localparam int CNT_W     = $clog2(BLOCK_MAX + 1);

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic signed [31:0] word_t;

	typedef struct packed {
		logic  en;
		addr_t addr;
		word_t own;
		word_t partner;
	} wr_port_t;

	typedef struct packed {
		logic valid;
		cnt_t n;
		logic upper;
	} merge_cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PRIME,
		ST_MERGE,
		ST_DRAIN
	} back_state_t;

endpackage
`default_nettype wire

[src/sorted_block_merge_split.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_block_merge_split: compare-split step of block odd-even sort
// Loads two sorted blocks pairwise, then emits the lower or upper half of
// their merge in ascending order.
//
//  channel  | handshake            | words
//  ---------+----------------------+--------------------------------------------
//  input    | start / busy         | first_value, second_value, keep_upper, load_last
//  result   | strobe (no stall)    | kept_value, kept_last
//
// One pair is stored per cycle while busy is low. After the last pair, busy
// stays high while the back end primes its heads, merges through the single
// read port of each block store and, for the upper half, drains the reorder
// buffer. Results come one per cycle, from the merge (lower half) or from the
// reorder buffer readout (upper half). Asynchronous reset clears all control
// state; block contents are undefined until loaded.
// ----------------------------------------------------------------------------
module sorted_block_merge_split (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  sbms_pkg::word_t first_value,
	input  sbms_pkg::word_t second_value,
	input  logic            keep_upper,
	input  logic            load_last,
	output logic            strobe,
	output sbms_pkg::word_t kept_value,
	output logic            kept_last
);

	sbms_pkg::wr_port_t   wr;
	sbms_pkg::merge_cmd_t cmd;
	logic                 cmd_pop;
	logic                 back_busy;

	sbms_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.first_value  (first_value),
		.second_value (second_value),
		.keep_upper   (keep_upper),
		.load_last    (load_last),
		.cmd_pop      (cmd_pop),
		.back_busy    (back_busy),
		.busy         (busy),
		.wr           (wr),
		.cmd          (cmd)
	);

	sbms_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr         (wr),
		.cmd        (cmd),
		.cmd_pop    (cmd_pop),
		.back_busy  (back_busy),
		.strobe     (strobe),
		.kept_value (kept_value),
		.kept_last  (kept_last)
	);

endmodule
`default_nettype wire

[src/sbms_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sbms_front: load front end
// Takes element pairs, writes them to the block stores and queues one merge
// command per load in a single-entry command register.
// ----------------------------------------------------------------------------
module sbms_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  sbms_pkg::word_t      first_value,
	input  sbms_pkg::word_t      second_value,
	input  logic                 keep_upper,
	input  logic                 load_last,
	input  logic                 cmd_pop,
	input  logic                 back_busy,
	output logic                 busy,
	output sbms_pkg::wr_port_t   wr,
	output sbms_pkg::merge_cmd_t cmd
);

	sbms_pkg::cnt_t       load_count_q;
	sbms_pkg::cnt_t       n_next;
	sbms_pkg::merge_cmd_t cmd_q;
	logic                 accept;
	logic                 room;

	assign busy   = cmd_q.valid || back_busy;
	assign accept = start && !busy;
	assign room   = load_count_q < sbms_pkg::cnt_t'(sbms_pkg::BLOCK_MAX);
	assign n_next = load_count_q + sbms_pkg::cnt_t'(room);

	assign wr.en      = accept && room;
	assign wr.addr    = load_count_q[sbms_pkg::ADDR_W-1:0];
	assign wr.own     = first_value;
	assign wr.partner = second_value;
	assign cmd        = cmd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_count_q <= '0;
			cmd_q        <= '0;
		end else begin
			if (accept) begin
				load_count_q <= load_last ? '0 : n_next;
			end
			if (accept && load_last) begin
				cmd_q.valid <= 1'b1;
				cmd_q.n     <= n_next;
				cmd_q.upper <= keep_upper;
			end else if (cmd_pop) begin
				cmd_q.valid <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

[src/sbms_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sbms_back: merge engine
// Holds both block stores, merges them one word per cycle with prefetched
// heads, and emits the kept half ascending (upper half via a reorder buffer).
// ----------------------------------------------------------------------------
module sbms_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sbms_pkg::wr_port_t   wr,
	input  sbms_pkg::merge_cmd_t cmd,
	output logic                 cmd_pop,
	output logic                 back_busy,
	output logic                 strobe,
	output sbms_pkg::word_t      kept_value,
	output logic                 kept_last
);

	sbms_pkg::word_t own_mem  [sbms_pkg::BLOCK_MAX];
	sbms_pkg::word_t part_mem [sbms_pkg::BLOCK_MAX];
	sbms_pkg::word_t buf_mem  [sbms_pkg::BLOCK_MAX];

	sbms_pkg::back_state_t state_q, state_d;

	logic            upper_q;
	sbms_pkg::cnt_t  n_q, own_left_q, part_left_q, k_q, drain_q;
	sbms_pkg::addr_t own_ptr_q, part_ptr_q, own_ptr_d, part_ptr_d;
	sbms_pkg::addr_t own_raddr, part_raddr, buf_waddr, buf_raddr, step;
	sbms_pkg::word_t own_rd_q, part_rd_q, buf_rd_q;
	sbms_pkg::word_t own_head_q, part_head_q, merge_val, out_value_q;
	logic            pend_s1, pend_last_s1, out_valid_q, out_last_q;
	logic            take_own, merge_end, drain_end, buf_we, lower_emit;

	assign step      = upper_q ? '1 : sbms_pkg::addr_t'(1);
	assign merge_end = k_q == n_q - sbms_pkg::cnt_t'(1);
	assign drain_end = drain_q == n_q - sbms_pkg::cnt_t'(1);
	assign take_own  = (part_left_q == '0) ||
		((own_left_q != '0) &&
		(upper_q ? (own_head_q >= part_head_q) : (own_head_q <= part_head_q)));
	assign merge_val = take_own ? own_head_q : part_head_q;
	assign buf_waddr = sbms_pkg::addr_t'(n_q - sbms_pkg::cnt_t'(1) - k_q);
	assign buf_raddr = drain_q[sbms_pkg::ADDR_W-1:0];

	assign back_busy  = state_q != sbms_pkg::ST_IDLE;
	assign strobe     = out_valid_q;
	assign kept_value = out_value_q;
	assign kept_last  = out_last_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sbms_pkg::ST_IDLE: begin
				if (cmd.valid) state_d = sbms_pkg::ST_PRIME;
			end
			sbms_pkg::ST_PRIME: begin
				state_d = sbms_pkg::ST_MERGE;
			end
			sbms_pkg::ST_MERGE: begin
				if (merge_end) state_d = upper_q ? sbms_pkg::ST_DRAIN : sbms_pkg::ST_IDLE;
			end
			sbms_pkg::ST_DRAIN: begin
				if (drain_end) state_d = sbms_pkg::ST_IDLE;
			end
			default: state_d = sbms_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		own_ptr_d  = own_ptr_q;
		part_ptr_d = part_ptr_q;
		cmd_pop    = 1'b0;
		buf_we     = 1'b0;
		lower_emit = 1'b0;
		unique case (state_q)
			sbms_pkg::ST_IDLE: begin
				cmd_pop = cmd.valid;
				if (cmd.valid) begin
					own_ptr_d  = cmd.upper ? sbms_pkg::addr_t'(cmd.n - sbms_pkg::cnt_t'(1)) : '0;
					part_ptr_d = own_ptr_d;
				end
			end
			sbms_pkg::ST_PRIME: begin
			end
			sbms_pkg::ST_MERGE: begin
				buf_we     = upper_q;
				lower_emit = !upper_q;
				if (take_own) own_ptr_d = own_ptr_q + step;
				else part_ptr_d = part_ptr_q + step;
			end
			sbms_pkg::ST_DRAIN: begin
			end
			default: begin
			end
		endcase
		// head index while idle, next-after-head once the heads are live
		own_raddr  = (state_q == sbms_pkg::ST_IDLE) ? own_ptr_d : own_ptr_d + step;
		part_raddr = (state_q == sbms_pkg::ST_IDLE) ? part_ptr_d : part_ptr_d + step;
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			own_mem[wr.addr]  <= wr.own;
			part_mem[wr.addr] <= wr.partner;
		end
		own_rd_q  <= own_mem[own_raddr];
		part_rd_q <= part_mem[part_raddr];
	end

	always_ff @(posedge clk) begin
		if (buf_we) begin
			buf_mem[buf_waddr] <= merge_val;
		end
		buf_rd_q <= buf_mem[buf_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= sbms_pkg::ST_IDLE;
			upper_q      <= 1'b0;
			n_q          <= '0;
			own_left_q   <= '0;
			part_left_q  <= '0;
			k_q          <= '0;
			drain_q      <= '0;
			own_ptr_q    <= '0;
			part_ptr_q   <= '0;
			pend_s1      <= 1'b0;
			pend_last_s1 <= 1'b0;
			out_valid_q  <= 1'b0;
			out_last_q   <= 1'b0;
		end else begin
			state_q    <= state_d;
			own_ptr_q  <= own_ptr_d;
			part_ptr_q <= part_ptr_d;
			if (cmd_pop) begin
				upper_q     <= cmd.upper;
				n_q         <= cmd.n;
				own_left_q  <= cmd.n;
				part_left_q <= cmd.n;
				k_q         <= '0;
				drain_q     <= '0;
			end
			if (state_q == sbms_pkg::ST_MERGE) begin
				k_q <= k_q + sbms_pkg::cnt_t'(1);
				if (take_own) own_left_q <= own_left_q - sbms_pkg::cnt_t'(1);
				else part_left_q <= part_left_q - sbms_pkg::cnt_t'(1);
			end
			if (state_q == sbms_pkg::ST_DRAIN) begin
				drain_q <= drain_q + sbms_pkg::cnt_t'(1);
			end
			pend_s1      <= state_q == sbms_pkg::ST_DRAIN;
			pend_last_s1 <= (state_q == sbms_pkg::ST_DRAIN) && drain_end;
			out_valid_q  <= lower_emit || pend_s1;
			out_last_q   <= (lower_emit && merge_end) || (pend_s1 && pend_last_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == sbms_pkg::ST_PRIME) begin
			own_head_q  <= own_rd_q;
			part_head_q <= part_rd_q;
		end else if (state_q == sbms_pkg::ST_MERGE) begin
			if (take_own) own_head_q <= own_rd_q;
			else part_head_q <= part_rd_q;
		end
		out_value_q <= pend_s1 ? buf_rd_q : merge_val;
	end

endmodule
`default_nettype wire

[src/sbms_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sbms_checker: port-level checks for sorted_block_merge_split
// Watches load closure, busy and the result strobe.
// ----------------------------------------------------------------------------
module sbms_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            start,
	input logic            busy,
	input logic            load_last,
	input logic            strobe,
	input logic            kept_last
);

	a_last_with_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		kept_last |-> strobe)
		else $error("kept_last without strobe");

	a_busy_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && load_last |=> busy)
		else $error("not busy after closing word");

	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && kept_last |=> !strobe)
		else $error("result word right after final word");

	a_results_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !kept_last |=> strobe)
		else $error("gap inside a result burst");

endmodule

bind sorted_block_merge_split sbms_checker u_sbms_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.load_last (load_last),
	.strobe    (strobe),
	.kept_last (kept_last)
);
`default_nettype wire

[dv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: sorted_block_merge_split compare-split check
// Loads pairs of sorted blocks through start/busy, predicts the kept half
// (lower or upper) of every merge and compares each strobed word, in order,
// against it. Directed loads cover the value extremes, ties, both halves and
// a keep flag that is ignored on items that are not last. Random loads follow,
// with random gaps. They include one load that fills and then overruns the
// block store, plus some unsorted blocks.
// ----------------------------------------------------------------------------
module testbench;

	localparam sbms_pkg::word_t WORD_MIN = 32'sh8000_0000;
	localparam sbms_pkg::word_t WORD_MAX = 32'sh7FFF_FFFF;

	class merge_scoreboard;
		sbms_pkg::word_t own_store[sbms_pkg::BLOCK_MAX];
		sbms_pkg::word_t partner_store[sbms_pkg::BLOCK_MAX];
		int              fill;
		sbms_pkg::word_t kept_value_q[$];
		bit              kept_last_q[$];
		int              errors;
		int              results;
		int              lower_merges;
		int              upper_merges;

		function void note_input(sbms_pkg::word_t a, sbms_pkg::word_t b, logic upper,
			logic last);
			sbms_pkg::word_t kept[sbms_pkg::BLOCK_MAX];
			int              i, j, k, n;
			if (fill < sbms_pkg::BLOCK_MAX) begin
				own_store[fill] = a;
				partner_store[fill] = b;
				fill++;
			end
			if (!last)
				return;
			n = fill;
			if (upper) begin
				// walk down from the top, own block wins ties
				i = n;
				j = n;
				for (k = n - 1; k >= 0; k--) begin
					if (j == 0 || (i > 0 && own_store[i-1] >= partner_store[j-1])) begin
						i--;
						kept[k] = own_store[i];
					end else begin
						j--;
						kept[k] = partner_store[j];
					end
				end
				upper_merges++;
			end else begin
				i = 0;
				j = 0;
				for (k = 0; k < n; k++) begin
					if (j >= n || (i < n && own_store[i] <= partner_store[j])) begin
						kept[k] = own_store[i];
						i++;
					end else begin
						kept[k] = partner_store[j];
						j++;
					end
				end
				lower_merges++;
			end
			for (k = 0; k < n; k++) begin
				own_store[k] = kept[k];
				kept_value_q.push_back(kept[k]);
				kept_last_q.push_back(k == n - 1);
			end
			fill = 0;
		endfunction

		function void check(sbms_pkg::word_t value, logic last);
			sbms_pkg::word_t exp_value;
			bit              exp_last;
			results++;
			if (kept_value_q.size() == 0) begin
				$display("%0t: unexpected word: kept_value %0d kept_last %0b",
					$time, value, last);
				errors++;
				return;
			end
			exp_value = kept_value_q.pop_front();
			exp_last = kept_last_q.pop_front();
			if (value !== exp_value) begin
				$display("%0t: kept_value mismatch: expected %0d, got %0d",
					$time, exp_value, value);
				errors++;
			end
			if (last !== exp_last) begin
				$display("%0t: kept_last mismatch: expected %0b, got %0b",
					$time, exp_last, last);
				errors++;
			end
		endfunction

		function int pending();
			return kept_value_q.size();
		endfunction
	endclass

	logic            clk;
	logic            arst_n;
	logic            start;
	logic            busy;
	sbms_pkg::word_t first_value;
	sbms_pkg::word_t second_value;
	logic            keep_upper;
	logic            load_last;
	logic            strobe;
	sbms_pkg::word_t kept_value;
	logic            kept_last;

	merge_scoreboard sb = new();
	int              words_sent;
	int              overrun_loads;
	bit              no_gaps;

	sorted_block_merge_split dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.first_value (first_value),
		.second_value(second_value),
		.keep_upper  (keep_upper),
		.load_last   (load_last),
		.strobe      (strobe),
		.kept_value  (kept_value),
		.kept_last   (kept_last)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#1000000;
		$display("timeout with %0d words outstanding", sb.pending());
		$display("*** FAILED ***");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && strobe)
			sb.check(kept_value, kept_last);
	end

	function int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task send_word(input sbms_pkg::word_t a, input sbms_pkg::word_t b, input logic upper,
		input logic last);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		first_value <= a;
		second_value <= b;
		keep_upper <= upper;
		load_last <= last;
		do
			@(posedge clk);
		while (busy);
		sb.note_input(a, b, upper, last);
		words_sent++;
	endtask

	task send_load(input int n, input logic upper, input bit sorted, input bit narrow);
		sbms_pkg::word_t own_blk[sbms_pkg::BLOCK_MAX+4];
		sbms_pkg::word_t partner_blk[sbms_pkg::BLOCK_MAX+4];
		sbms_pkg::word_t t;
		int              i, j;
		for (i = 0; i < n; i++) begin
			own_blk[i] = narrow ? sbms_pkg::word_t'($urandom_range(0, 8)) - 4 :
				sbms_pkg::word_t'($urandom);
			partner_blk[i] = narrow ? sbms_pkg::word_t'($urandom_range(0, 8)) - 4 :
				sbms_pkg::word_t'($urandom);
		end
		if (sorted) begin
			for (i = 1; i < n; i++)
				for (j = i; j > 0 && own_blk[j-1] > own_blk[j]; j--) begin
					t = own_blk[j];
					own_blk[j] = own_blk[j-1];
					own_blk[j-1] = t;
				end
			for (i = 1; i < n; i++)
				for (j = i; j > 0 && partner_blk[j-1] > partner_blk[j]; j--) begin
					t = partner_blk[j];
					partner_blk[j] = partner_blk[j-1];
					partner_blk[j-1] = t;
				end
		end
		no_gaps = ($urandom_range(0, 3) == 0);
		for (i = 0; i < n; i++)
			send_word(own_blk[i], partner_blk[i],
				(i == n - 1) ? upper : logic'($urandom_range(0, 1)), i == n - 1);
		if (n > sbms_pkg::BLOCK_MAX)
			overrun_loads++;
	endtask

	initial begin
		int  n;
		bit  did_over;
		arst_n = 1'b0;
		start = 1'b0;
		first_value = '0;
		second_value = '0;
		keep_upper = 1'b0;
		load_last = 1'b0;
		no_gaps = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single pairs at the extremes, both halves
		send_word(WORD_MAX, WORD_MIN, 1'b0, 1'b1);
		send_word(WORD_MIN, WORD_MAX, 1'b1, 1'b1);
		send_word(WORD_MIN, WORD_MIN, 1'b1, 1'b1);
		// ties everywhere
		send_word(32'sd5, 32'sd5, 1'b0, 1'b0);
		send_word(32'sd5, 32'sd5, 1'b0, 1'b1);
		send_word(-32'sd1, -32'sd1, 1'b1, 1'b0);
		send_word(-32'sd1, -32'sd1, 1'b1, 1'b1);
		// interleaved, keep flag toggled on non-last words
		send_word(-32'sd3, -32'sd1, 1'b1, 1'b0);
		send_word(32'sd0, 32'sd2, 1'b1, 1'b0);
		send_word(32'sd7, 32'sd9, 1'b0, 1'b1);
		send_word(-32'sd3, -32'sd1, 1'b0, 1'b0);
		send_word(32'sd0, 32'sd2, 1'b0, 1'b0);
		send_word(32'sd7, 32'sd9, 1'b1, 1'b1);
		// one block mostly below the other
		send_word(WORD_MIN, 32'sd0, 1'b0, 1'b0);
		send_word(-32'sd1, 32'sh5555_5555, 1'b0, 1'b0);
		send_word(32'sh0000_0001, WORD_MAX, 1'b0, 1'b1);
		send_word(32'sd0, WORD_MIN, 1'b1, 1'b0);
		send_word(32'sh5555_5555, -32'sd1, 1'b1, 1'b0);
		send_word(WORD_MAX, 32'sh0000_0001, 1'b1, 1'b1);

		did_over = 1'b0;
		while (words_sent < 125 || !did_over) begin
			if (!did_over && (words_sent >= 40 || $urandom_range(0, 7) == 0)) begin
				n = sbms_pkg::BLOCK_MAX + int'($urandom_range(1, 3));
				did_over = 1'b1;
			end else if ($urandom_range(0, 3) == 0)
				n = $urandom_range(9, 20);
			else
				n = $urandom_range(1, 8);
			send_load(n, logic'($urandom_range(0, 1)), $urandom_range(0, 6) != 0,
				$urandom_range(0, 3) == 0);
		end
		start <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (2 * sbms_pkg::BLOCK_MAX + 8) @(posedge clk);

		$display("%0d words loaded, %0d lower and %0d upper merges, %0d kept words checked",
			words_sent, sb.lower_merges, sb.upper_merges, sb.results);
		$display("%0d overrunning load(s), %0d error(s)", overrun_loads, sb.errors);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

[sim.f]
src/sbms_pkg.sv
src/sbms_front.sv
src/sbms_back.sv
src/sorted_block_merge_split.sv
src/sbms_checker.sv
dv/testbench.sv
